[rtl/lps_pkg.sv]
// ----------------------------------------------------------------------------
// lps_pkg
// Shared constants, state encoding and fixed-point helpers for the LU solver.
// ----------------------------------------------------------------------------
package lps_pkg;

    localparam int ORDER     = 4;
    localparam int COLS      = ORDER + 1;
    localparam int FRAC      = 16;
    localparam int DATA_W    = 32;
    localparam int ROW_W     = 2;
    localparam int COL_W     = 3;
    localparam int IDX_W     = $clog2(ORDER);
    localparam int CNT_W     = $clog2(ORDER + 1);
    localparam int MAT_DEPTH = ORDER * COLS;
    localparam int ADDR_W    = $clog2(MAT_DEPTH);
    localparam int DIV_STEPS = DATA_W + FRAC + 1;
    localparam int DIV_CW    = $clog2(DIV_STEPS + 1);

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_INIT,
        ST_PIV_RD,
        ST_PIV_CMP,
        ST_PIV_SWAP,
        ST_EL_RD,
        ST_EL_DIV,
        ST_EL_DWAIT,
        ST_EL_RDP,
        ST_EL_MUL,
        ST_EL_SUB,
        ST_EL_WS,
        ST_FW_ARD,
        ST_FW_ACC,
        ST_FW_RA,
        ST_FW_RB,
        ST_FW_MUL,
        ST_FW_SUB,
        ST_FW_WR,
        ST_BK_ARD,
        ST_BK_ACC,
        ST_BK_RA,
        ST_BK_MUL,
        ST_BK_SUB,
        ST_BK_DRD,
        ST_BK_DIV,
        ST_BK_DWAIT,
        ST_OUT
    } state_t;

    function automatic logic [DATA_W-1:0] mag(input logic signed [DATA_W-1:0] v);
        logic [DATA_W-1:0] m;
        m = v[DATA_W-1] ? (~v + 1'b1) : v;
        return m;
    endfunction

    // Saturates a magnitude with a sign to the signed data range.
    function automatic logic signed [DATA_W-1:0] fx_sat(input logic [63:0] m, input logic neg);
        logic signed [DATA_W-1:0] r;
        if (neg) begin
            if (m > 64'(1) << (DATA_W - 1))
                r = {1'b1, {(DATA_W-1){1'b0}}};
            else
                r = DATA_W'(~m + 64'd1);
        end
        else begin
            if (m > (64'(1) << (DATA_W - 1)) - 64'd1)
                r = {1'b0, {(DATA_W-1){1'b1}}};
            else
                r = DATA_W'(m);
        end
        return r;
    endfunction

    function automatic logic signed [DATA_W-1:0] fx_mul(input logic signed [DATA_W-1:0] a,
                                                       input logic signed [DATA_W-1:0] b);
        logic [63:0] p;
        logic [63:0] r;
        p = 64'(mag(a)) * 64'(mag(b));
        r = (p + (64'(1) << (FRAC - 1))) >> FRAC;
        return fx_sat(r, a[DATA_W-1] ^ b[DATA_W-1]);
    endfunction

    function automatic logic signed [DATA_W-1:0] fx_sub(input logic signed [DATA_W-1:0] a,
                                                       input logic signed [DATA_W-1:0] b);
        logic signed [DATA_W:0] d;
        logic signed [DATA_W-1:0] r;
        d = (DATA_W+1)'(a) - (DATA_W+1)'(b);
        if (d[DATA_W] != d[DATA_W-1])
            r = d[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
        else
            r = d[DATA_W-1:0];
        return r;
    endfunction

    function automatic logic [ADDR_W-1:0] addr_of(input logic [IDX_W-1:0] row,
                                                 input logic [CNT_W-1:0] col);
        return ADDR_W'(int'(row) * COLS + int'(col));
    endfunction

endpackage

[rtl/lps_ram.sv]
// ----------------------------------------------------------------------------
// lps_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module lps_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 20
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/lps_div.sv]
// ----------------------------------------------------------------------------
// lps_div
// Restoring fixed-point divider, one quotient bit per cycle, rounded, saturated.
// ----------------------------------------------------------------------------
module lps_div (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic signed [lps_pkg::DATA_W-1:0] num,
    input  logic signed [lps_pkg::DATA_W-1:0] den,
    output logic                             done,
    output logic signed [lps_pkg::DATA_W-1:0] quot
);

    logic                              busy_reg;
    logic [lps_pkg::DIV_CW-1:0]        cnt_reg;
    logic [lps_pkg::DATA_W-1:0]        rem_reg;
    logic [lps_pkg::DATA_W-1:0]        den_reg;
    logic [lps_pkg::DIV_STEPS-1:0]     dvd_reg;
    logic                              neg_reg;
    logic                              done_reg;
    logic signed [lps_pkg::DATA_W-1:0] quot_reg;
    logic [lps_pkg::DATA_W:0]          rem_sh;
    logic                              fits;
    logic [63:0]                       dvd_init;

    assign rem_sh   = {rem_reg, dvd_reg[lps_pkg::DIV_STEPS-1]};
    assign fits     = rem_sh >= {1'b0, den_reg};
    assign dvd_init = (64'(lps_pkg::mag(num)) << lps_pkg::FRAC) + 64'(lps_pkg::mag(den) >> 1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                if (den == '0)
                begin
                    done_reg <= 1'b1;
                end
                else
                begin
                    busy_reg <= 1'b1;
                    cnt_reg  <= '0;
                end
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == lps_pkg::DIV_CW'(lps_pkg::DIV_STEPS))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= '0;
            den_reg  <= lps_pkg::mag(den);
            dvd_reg  <= dvd_init[lps_pkg::DIV_STEPS-1:0];
            neg_reg  <= num[lps_pkg::DATA_W-1] ^ den[lps_pkg::DATA_W-1];
            quot_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == lps_pkg::DIV_CW'(lps_pkg::DIV_STEPS))
            begin
                quot_reg <= lps_pkg::fx_sat(64'(dvd_reg), neg_reg);
            end
            else
            begin
                rem_reg <= fits ? lps_pkg::DATA_W'(rem_sh - {1'b0, den_reg})
                                : rem_sh[lps_pkg::DATA_W-1:0];
                dvd_reg <= {dvd_reg[lps_pkg::DIV_STEPS-2:0], fits};
            end
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

[rtl/lu_pivot_linear_solver_top.sv]
// Operation: after the last load the factor and solve run on one multiplier, one
// subtractor and one bit-serial divider for a 4x4 system.
// Throughput: one system at a time; loads are stalled from the last load until the
// fourth result transaction is taken.
// Reset: asynchronous, active low; returns the sequencer to idle, clears the flag.
// ----------------------------------------------------------------------------
// lu_pivot_linear_solver_top
// LU factorization with partial pivoting and forward/back substitution over a
// loaded augmented matrix in signed Q16.16.
// ----------------------------------------------------------------------------
module lu_pivot_linear_solver_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              item_valid,
    output logic                              item_stall,
    input  logic [lps_pkg::ROW_W-1:0]         row_index,
    input  logic [lps_pkg::COL_W-1:0]         col_index,
    input  logic signed [lps_pkg::DATA_W-1:0] entry_value,
    input  logic                              load_last,
    output logic                              result_valid,
    input  logic                              result_stall,
    output logic [lps_pkg::ROW_W-1:0]         solution_index,
    output logic signed [lps_pkg::DATA_W-1:0] solution_value,
    output logic                              singular,
    output logic                              result_last
);

    lps_pkg::state_t state_reg, state_next;

    // Sequencer counters: k is the pivot step, i the row, c the column.
    logic [lps_pkg::CNT_W-1:0]         k_reg, i_reg, c_reg;
    logic [lps_pkg::IDX_W-1:0]         perm_reg [lps_pkg::ORDER];
    logic [lps_pkg::IDX_W-1:0]         best_reg;
    logic [lps_pkg::DATA_W-1:0]        best_mag_reg;
    logic signed [lps_pkg::DATA_W-1:0] pv_reg;
    logic signed [lps_pkg::DATA_W-1:0] opa_reg;
    logic signed [lps_pkg::DATA_W-1:0] acc_reg;
    logic signed [lps_pkg::DATA_W-1:0] mul_reg;
    logic signed [lps_pkg::DATA_W-1:0] sol_reg [lps_pkg::ORDER];
    logic                              sing_reg;
    logic [lps_pkg::IDX_W-1:0]         oidx_reg;

    logic                              in_acc, out_acc;
    logic                              we;
    logic [lps_pkg::ADDR_W-1:0]        waddr, raddr;
    logic signed [lps_pkg::DATA_W-1:0] wdata, rdata;
    logic signed [lps_pkg::DATA_W-1:0] mul_a, sub_a, div_num, div_den, div_q;
    logic                              div_start, div_done;
    logic [lps_pkg::IDX_W-1:0]         k_i, i_i, c_i, row_r, piv_r;

    assign k_i   = k_reg[lps_pkg::IDX_W-1:0];
    assign i_i   = i_reg[lps_pkg::IDX_W-1:0];
    assign c_i   = c_reg[lps_pkg::IDX_W-1:0];
    assign row_r = perm_reg[i_i];
    assign piv_r = perm_reg[k_i];

    assign in_acc  = item_valid && !item_stall;
    assign out_acc = result_valid && !result_stall;

    lps_ram #(
        .WIDTH(lps_pkg::DATA_W),
        .DEPTH(lps_pkg::MAT_DEPTH)
    ) u_mat (
        .clk  (clk),
        .we   (we),
        .waddr(waddr),
        .wdata(wdata),
        .raddr(raddr),
        .rdata(rdata)
    );

    lps_div u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .start(div_start),
        .num  (div_num),
        .den  (div_den),
        .done (div_done),
        .quot (div_q)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lps_pkg::ST_IDLE:     if (in_acc && load_last) state_next = lps_pkg::ST_INIT;
            lps_pkg::ST_INIT:     state_next = lps_pkg::ST_PIV_RD;
            lps_pkg::ST_PIV_RD:   state_next = lps_pkg::ST_PIV_CMP;
            lps_pkg::ST_PIV_CMP:
                state_next = (i_reg == lps_pkg::CNT_W'(lps_pkg::ORDER - 1))
                             ? lps_pkg::ST_PIV_SWAP : lps_pkg::ST_PIV_RD;
            lps_pkg::ST_PIV_SWAP:
                state_next = (k_reg == lps_pkg::CNT_W'(lps_pkg::ORDER - 1))
                             ? lps_pkg::ST_FW_ARD : lps_pkg::ST_EL_RD;
            lps_pkg::ST_EL_RD:    state_next = lps_pkg::ST_EL_DIV;
            lps_pkg::ST_EL_DIV:   state_next = lps_pkg::ST_EL_DWAIT;
            lps_pkg::ST_EL_DWAIT:
                if (div_done)
                    state_next = (k_reg == lps_pkg::CNT_W'(lps_pkg::ORDER - 1))
                                 ? lps_pkg::ST_EL_WS : lps_pkg::ST_EL_RDP;
            lps_pkg::ST_EL_RDP:   state_next = lps_pkg::ST_EL_MUL;
            lps_pkg::ST_EL_MUL:   state_next = lps_pkg::ST_EL_SUB;
            lps_pkg::ST_EL_SUB:
                state_next = (c_reg == lps_pkg::CNT_W'(lps_pkg::ORDER - 1))
                             ? lps_pkg::ST_EL_WS : lps_pkg::ST_EL_RDP;
            lps_pkg::ST_EL_WS:
                state_next = (i_reg == lps_pkg::CNT_W'(lps_pkg::ORDER - 1))
                             ? lps_pkg::ST_PIV_RD : lps_pkg::ST_EL_RD;
            lps_pkg::ST_FW_ARD:   state_next = lps_pkg::ST_FW_ACC;
            lps_pkg::ST_FW_ACC:
                state_next = (i_reg == '0) ? lps_pkg::ST_FW_WR : lps_pkg::ST_FW_RA;
            lps_pkg::ST_FW_RA:    state_next = lps_pkg::ST_FW_RB;
            lps_pkg::ST_FW_RB:    state_next = lps_pkg::ST_FW_MUL;
            lps_pkg::ST_FW_MUL:   state_next = lps_pkg::ST_FW_SUB;
            lps_pkg::ST_FW_SUB:
                state_next = (c_reg + 1'b1 == i_reg) ? lps_pkg::ST_FW_WR : lps_pkg::ST_FW_RA;
            lps_pkg::ST_FW_WR:
                state_next = (i_reg == lps_pkg::CNT_W'(lps_pkg::ORDER - 1))
                             ? lps_pkg::ST_BK_ARD : lps_pkg::ST_FW_ARD;
            lps_pkg::ST_BK_ARD:   state_next = lps_pkg::ST_BK_ACC;
            lps_pkg::ST_BK_ACC:
                state_next = (c_reg == i_reg) ? lps_pkg::ST_BK_DRD : lps_pkg::ST_BK_RA;
            lps_pkg::ST_BK_RA:    state_next = lps_pkg::ST_BK_MUL;
            lps_pkg::ST_BK_MUL:   state_next = lps_pkg::ST_BK_SUB;
            lps_pkg::ST_BK_SUB:
                state_next = (c_reg == i_reg + 1'b1) ? lps_pkg::ST_BK_DRD : lps_pkg::ST_BK_RA;
            lps_pkg::ST_BK_DRD:   state_next = lps_pkg::ST_BK_DIV;
            lps_pkg::ST_BK_DIV:   state_next = lps_pkg::ST_BK_DWAIT;
            lps_pkg::ST_BK_DWAIT:
                if (div_done)
                    state_next = (i_reg == '0) ? lps_pkg::ST_OUT : lps_pkg::ST_BK_ARD;
            lps_pkg::ST_OUT:
                if (out_acc && oidx_reg == lps_pkg::IDX_W'(lps_pkg::ORDER - 1))
                    state_next = lps_pkg::ST_IDLE;
            default:              state_next = lps_pkg::ST_IDLE;
        endcase
    end

    // Memory ports, shared arithmetic operands and handshake outputs.
    always_comb
    begin
        we        = 1'b0;
        waddr     = lps_pkg::addr_of(row_r, c_reg);
        wdata     = '0;
        raddr     = lps_pkg::addr_of(row_r, k_reg);
        div_start = 1'b0;
        div_num   = rdata;
        div_den   = pv_reg;
        mul_a     = opa_reg;
        sub_a     = acc_reg;
        unique case (state_reg) inside
            lps_pkg::ST_IDLE:
            begin
                we    = in_acc && (32'(row_index) < lps_pkg::ORDER)
                              && (32'(col_index) <= lps_pkg::ORDER);
                waddr = lps_pkg::addr_of(lps_pkg::IDX_W'(row_index),
                                         lps_pkg::CNT_W'(col_index));
                wdata = entry_value;
            end
            lps_pkg::ST_EL_DIV:   div_start = 1'b1;
            lps_pkg::ST_EL_RDP:   raddr = lps_pkg::addr_of(piv_r, c_reg);
            lps_pkg::ST_EL_MUL:   raddr = lps_pkg::addr_of(row_r, c_reg);
            lps_pkg::ST_EL_SUB:
            begin
                we    = 1'b1;
                sub_a = rdata;
                wdata = lps_pkg::fx_sub(sub_a, mul_reg);
            end
            lps_pkg::ST_EL_WS:
            begin
                we    = 1'b1;
                waddr = lps_pkg::addr_of(row_r, k_reg);
                wdata = opa_reg;
            end
            lps_pkg::ST_FW_ARD, lps_pkg::ST_BK_ARD:
                raddr = lps_pkg::addr_of(row_r, lps_pkg::CNT_W'(lps_pkg::ORDER));
            lps_pkg::ST_FW_RA, lps_pkg::ST_BK_RA:
                raddr = lps_pkg::addr_of(row_r, c_reg);
            lps_pkg::ST_FW_RB:
                raddr = lps_pkg::addr_of(perm_reg[c_i], lps_pkg::CNT_W'(lps_pkg::ORDER));
            lps_pkg::ST_FW_WR:
            begin
                we    = 1'b1;
                waddr = lps_pkg::addr_of(row_r, lps_pkg::CNT_W'(lps_pkg::ORDER));
                wdata = acc_reg;
            end
            lps_pkg::ST_BK_MUL:   mul_a = sol_reg[c_i];
            lps_pkg::ST_BK_DRD:   raddr = lps_pkg::addr_of(row_r, i_reg);
            lps_pkg::ST_BK_DIV:
            begin
                div_start = 1'b1;
                div_num   = acc_reg;
                div_den   = rdata;
            end
            default:              we = 1'b0;
        endcase
    end

    assign item_stall     = (state_reg != lps_pkg::ST_IDLE);
    assign result_valid   = (state_reg == lps_pkg::ST_OUT);
    assign solution_index = lps_pkg::ROW_W'(oidx_reg);
    assign solution_value = sol_reg[oidx_reg];
    assign singular       = sing_reg;
    assign result_last    = (oidx_reg == lps_pkg::IDX_W'(lps_pkg::ORDER - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= lps_pkg::ST_IDLE;
            sing_reg     <= 1'b0;
            oidx_reg     <= '0;
            k_reg        <= '0;
            i_reg        <= '0;
            c_reg        <= '0;
            best_reg     <= '0;
            best_mag_reg <= '0;
            pv_reg       <= '0;
            opa_reg      <= '0;
            acc_reg      <= '0;
            mul_reg      <= '0;
            for (int n = 0; n < lps_pkg::ORDER; n++)
            begin
                perm_reg[n] <= lps_pkg::IDX_W'(n);
                sol_reg[n]  <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg) inside
                lps_pkg::ST_INIT:
                begin
                    // Every run starts from the identity row order.
                    for (int n = 0; n < lps_pkg::ORDER; n++)
                    begin
                        perm_reg[n] <= lps_pkg::IDX_W'(n);
                    end
                    sing_reg     <= 1'b0;
                    k_reg        <= '0;
                    i_reg        <= '0;
                    best_reg     <= '0;
                    best_mag_reg <= '0;
                    pv_reg       <= '0;
                end
                lps_pkg::ST_PIV_CMP:
                begin
                    // Strict compare keeps the first row on a tie.
                    if (lps_pkg::mag(rdata) > best_mag_reg)
                    begin
                        best_mag_reg <= lps_pkg::mag(rdata);
                        best_reg     <= i_i;
                        pv_reg       <= rdata;
                    end
                    if (i_reg != lps_pkg::CNT_W'(lps_pkg::ORDER - 1))
                    begin
                        i_reg <= i_reg + 1'b1;
                    end
                end
                lps_pkg::ST_PIV_SWAP:
                begin
                    if (best_mag_reg == '0)
                    begin
                        sing_reg <= 1'b1;
                    end
                    if (best_reg != k_i)
                    begin
                        perm_reg[k_i]      <= perm_reg[best_reg];
                        perm_reg[best_reg] <= perm_reg[k_i];
                    end
                    i_reg <= (k_reg == lps_pkg::CNT_W'(lps_pkg::ORDER - 1)) ? '0 : k_reg + 1'b1;
                end
                lps_pkg::ST_EL_DWAIT:
                begin
                    if (div_done)
                    begin
                        opa_reg <= div_q;
                        c_reg   <= k_reg + 1'b1;
                    end
                end
                lps_pkg::ST_EL_MUL, lps_pkg::ST_FW_MUL, lps_pkg::ST_BK_MUL:
                    mul_reg <= lps_pkg::fx_mul(mul_a, rdata);
                lps_pkg::ST_EL_SUB:   c_reg <= c_reg + 1'b1;
                lps_pkg::ST_EL_WS:
                begin
                    if (i_reg == lps_pkg::CNT_W'(lps_pkg::ORDER - 1))
                    begin
                        k_reg        <= k_reg + 1'b1;
                        i_reg        <= k_reg + 1'b1;
                        best_reg     <= lps_pkg::IDX_W'(k_reg + 1'b1);
                        best_mag_reg <= '0;
                        pv_reg       <= '0;
                    end
                    else
                    begin
                        i_reg <= i_reg + 1'b1;
                    end
                end
                lps_pkg::ST_FW_ACC:
                begin
                    acc_reg <= rdata;
                    c_reg   <= '0;
                end
                lps_pkg::ST_FW_RB:    opa_reg <= rdata;
                lps_pkg::ST_FW_SUB:
                begin
                    acc_reg <= lps_pkg::fx_sub(sub_a, mul_reg);
                    c_reg   <= c_reg + 1'b1;
                end
                lps_pkg::ST_FW_WR:
                begin
                    i_reg <= (i_reg == lps_pkg::CNT_W'(lps_pkg::ORDER - 1))
                             ? i_reg : i_reg + 1'b1;
                end
                lps_pkg::ST_BK_ACC:
                begin
                    acc_reg <= rdata;
                    c_reg   <= lps_pkg::CNT_W'(lps_pkg::ORDER - 1);
                end
                lps_pkg::ST_BK_SUB:
                begin
                    acc_reg <= lps_pkg::fx_sub(sub_a, mul_reg);
                    c_reg   <= c_reg - 1'b1;
                end
                lps_pkg::ST_BK_DWAIT:
                begin
                    if (div_done)
                    begin
                        sol_reg[i_i] <= div_q;
                        oidx_reg     <= '0;
                        if (i_reg != '0)
                        begin
                            i_reg <= i_reg - 1'b1;
                        end
                    end
                end
                lps_pkg::ST_OUT:
                begin
                    if (out_acc)
                    begin
                        oidx_reg <= oidx_reg + 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

endmodule

[rtl/lps_checker.sv]
// ----------------------------------------------------------------------------
// lps_checker
// Port-level checks on the LU solver's result sequence and load stalling.
// ----------------------------------------------------------------------------
module lps_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              item_valid,
    input logic                              item_stall,
    input logic                              result_valid,
    input logic                              result_stall,
    input logic [lps_pkg::ROW_W-1:0]         solution_index,
    input logic signed [lps_pkg::DATA_W-1:0] solution_value,
    input logic                              singular,
    input logic                              result_last
);

    // Loads are never taken while results are being shown.
    a_no_load_during_results: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && result_valid) |-> item_stall)
        else $error("load accepted while results pending");

    // The last result carries the highest unknown index.
    a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_last) |->
            (solution_index == lps_pkg::ROW_W'(lps_pkg::ORDER - 1)))
        else $error("result_last on wrong index");

    // Results come back to back until the last one is taken.
    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_stall && !result_last) |=>
            (result_valid && solution_index == $past(solution_index) + 1'b1))
        else $error("result run broken");

    // A stalled result holds.
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |=>
            (result_valid && $stable(solution_value) && $stable(singular)))
        else $error("stalled result changed");

endmodule

bind lu_pivot_linear_solver_top lps_checker u_lps_checker (.*);
